>>> rtl/apjb_pkg.sv
// apjb_pkg: shared types and constants of the audio playout jitter buffer
// used by the controller, datapath, top level and port checker; no dependencies

package apjb_pkg;

  // opcodes of a request
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_BLOCK  = 2'd0;
  localparam logic [1:0] CFG_PREBUF = 2'd1;
  localparam logic [1:0] CFG_CHAN   = 2'd2;
  localparam logic [1:0] CFG_INT16  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int BLK_W      = 7;
  localparam int PREBUF_W   = 11;
  localparam int CHAN_W     = 4;
  localparam int FREE_W     = 16;
  localparam int SAMPLE_W   = 24;
  localparam int UNDER_W    = 5;
  localparam int UNDERRUN_LIMIT = 25;

  localparam int FRAC_W      = 22;
  localparam int PROD_W      = 40;
  localparam int CLAMP_MAG   = 1 << FRAC_W;
  localparam int ROUND_BIAS  = (1 << FRAC_W) - 1;
  localparam int INT16_SCALE = 32767;

  localparam logic [BLK_W-1:0]    BLOCK_RST  = 7'd32;
  localparam logic [PREBUF_W-1:0] PREBUF_RST = 11'd256;
  localparam logic [CHAN_W-1:0]   CHAN_RST   = 4'd1;

  typedef struct packed {
    logic             push_acc;
    logic             push_wr;
    logic             flush;
    logic             low_space;
    logic             emit;
    logic [BLK_W-1:0] idx;
    logic             last;
    logic             silent;
  } apjb_cmd_t;

  typedef struct packed {
    logic             running;
    logic             space_low;
    logic             fill_short;
    logic [BLK_W-1:0] blk;
  } apjb_stat_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic silent;
  } apjb_meta_t;

endpackage

>>> rtl/apjb_ctrl.sv
// apjb_ctrl: request sequencer of the jitter buffer, drives the datapath commands
// depends on apjb_pkg

module apjb_ctrl import apjb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  opcode_i,
  input  logic        sink_suspended_i,
  input  apjb_stat_t  stat_i,
  output logic        busy_o,
  output apjb_cmd_t   cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WRITE = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [BLK_W-1:0] idx_q, idx_d;
  logic             silent_q, silent_d;
  logic             acc;
  logic             last;

  assign busy_o = (state_q != S_IDLE);
  assign acc    = start_i & ~busy_o;
  assign last   = (idx_q == BLK_W'(stat_i.blk - BLK_W'(1)));

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    silent_d = silent_q;
    cmd_o    = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (opcode_i)
            OP_PUSH: begin
              cmd_o.push_acc = 1'b1;
              state_d        = S_WRITE;
            end
            OP_FLUSH: begin
              cmd_o.flush = 1'b1;
            end
            OP_TICK: begin
              if (stat_i.running && !sink_suspended_i) begin
                if (stat_i.space_low) begin
                  cmd_o.low_space = 1'b1;
                end else begin
                  state_d  = S_EMIT;
                  idx_d    = '0;
                  silent_d = stat_i.fill_short;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WRITE: begin
        cmd_o.push_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_EMIT: begin
        cmd_o.emit   = 1'b1;
        cmd_o.idx    = idx_q;
        cmd_o.last   = last;
        cmd_o.silent = silent_q;
        if (last) begin
          state_d = S_IDLE;
        end else begin
          idx_d = BLK_W'(idx_q + BLK_W'(1));
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      silent_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      silent_q <= silent_d;
    end
  end

endmodule

>>> rtl/apjb_datapath.sv
// apjb_datapath: sample store, pointers, fill and level state, config registers
// and the int16 output pipeline; depends on apjb_pkg

module apjb_datapath import apjb_pkg::*; #(
  parameter int FIFO_DEPTH = 4096,
  parameter int MAX_BLOCK  = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       packet_start_i,
  input  logic [FREE_W-1:0]          sink_bytes_free_i,
  input  apjb_cmd_t                  cmd_i,
  output apjb_stat_t                 stat_o,
  output logic                       result_valid_o,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       is_silence_o,
  output logic                       last_of_block_o
);

  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int SUM_W   = PTR_W + 1;
  localparam int FILL_W  = $clog2(FIFO_DEPTH + 1);
  localparam int LVL_CAP = FIFO_DEPTH / 4;
  localparam int CAP_W   = $clog2(LVL_CAP + 1);
  localparam int LVL_W   = (CAP_W > PREBUF_W) ? CAP_W : PREBUF_W;
  localparam int CMP_W   = ((FILL_W > LVL_W) ? FILL_W : LVL_W) + 3;
  localparam int DROP_W  = BLK_W + 1;
  localparam int HALF_W  = BLK_W + CHAN_W + 1;

  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] x);
    if (x >= SUM_W'(FIFO_DEPTH)) begin
      wrap = PTR_W'(x - SUM_W'(FIFO_DEPTH));
    end else begin
      wrap = x[PTR_W-1:0];
    end
  endfunction

  logic [BLK_W-1:0]    blk_reg_q;
  logic [CHAN_W-1:0]   chan_q;
  logic                int16_q;
  logic [BLK_W-1:0]    eff_blk;

  logic [PTR_W-1:0]    rd_q, rd_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [UNDER_W-1:0]  ucnt_q, ucnt_d;
  logic                run_q, run_d;
  logic signed [SAMPLE_W-1:0] push_q;

  logic [SAMPLE_W-1:0] store_q [FIFO_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [PTR_W-1:0]    waddr, raddr;

  logic [CMP_W-1:0]    fill_ext, lvl_ext;
  logic                over4, over3;
  logic [BLK_W+CHAN_W-1:0] blkch;
  logic [HALF_W-1:0]   half_bytes;

  logic [DROP_W-1:0]   drop_n;
  logic [FILL_W-1:0]   drop_sat;
  logic                full;
  logic [FILL_W-1:0]   fill_new;
  logic [LVL_W:0]      lvl_sum;
  logic [UNDER_W-1:0]  ucnt_inc;

  apjb_meta_t          meta0_q, meta1_q, meta2_q;
  logic signed [SAMPLE_W-1:0] v_s, clamp_s, samp1_q, sample_q;
  logic signed [PROD_W-1:0]   prod_q, adj, conv;
  logic signed [SAMPLE_W-1:0] sample_d;

  // config registers
  always_comb begin
    if (blk_reg_q == '0) begin
      eff_blk = BLK_W'(1);
    end else if (blk_reg_q > BLK_W'(MAX_BLOCK)) begin
      eff_blk = BLK_W'(MAX_BLOCK);
    end else begin
      eff_blk = blk_reg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_reg_q <= BLOCK_RST;
      chan_q    <= CHAN_RST;
      int16_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_BLOCK: blk_reg_q <= cfg_wdata_i[BLK_W-1:0];
        CFG_CHAN:  chan_q    <= cfg_wdata_i[CHAN_W-1:0];
        CFG_INT16: int16_q   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // status towards the controller
  assign fill_ext   = CMP_W'(fill_q);
  assign lvl_ext    = CMP_W'(lvl_q);
  assign over4      = fill_ext > CMP_W'(lvl_ext << 2);
  assign over3      = fill_ext > CMP_W'((lvl_ext << 1) + lvl_ext);
  assign blkch      = (BLK_W + CHAN_W)'(eff_blk) * (BLK_W + CHAN_W)'(chan_q);
  assign half_bytes = int16_q ? HALF_W'(blkch) : {blkch, 1'b0};

  assign stat_o.running    = run_q;
  assign stat_o.space_low  = sink_bytes_free_i < FREE_W'(half_bytes);
  assign stat_o.fill_short = fill_ext < CMP_W'(eff_blk);
  assign stat_o.blk        = eff_blk;

  // oldest-sample drop amount
  always_comb begin
    drop_n = '0;
    if (cmd_i.push_acc && packet_start_i && over4) begin
      drop_n = {eff_blk, 1'b0};
    end else if (cmd_i.low_space && over3) begin
      drop_n = DROP_W'(eff_blk);
    end else if (cmd_i.emit && cmd_i.last && !cmd_i.silent) begin
      drop_n = DROP_W'(eff_blk);
    end
    if (fill_q < FILL_W'(drop_n)) begin
      drop_sat = fill_q;
    end else begin
      drop_sat = FILL_W'(drop_n);
    end
  end

  assign full     = (fill_q == FILL_W'(FIFO_DEPTH));
  assign fill_new = full ? fill_q : FILL_W'(fill_q + FILL_W'(1));
  assign waddr    = full ? rd_q : wrap(SUM_W'(rd_q) + SUM_W'(fill_q));
  assign raddr    = wrap(SUM_W'(rd_q) + SUM_W'(cmd_i.idx));
  assign lvl_sum  = (LVL_W + 1)'(lvl_q) + (LVL_W + 1)'(eff_blk);
  assign ucnt_inc = UNDER_W'(ucnt_q + UNDER_W'(1));

  always_comb begin
    rd_d   = rd_q;
    fill_d = fill_q;
    lvl_d  = lvl_q;
    ucnt_d = ucnt_q;
    run_d  = run_q;
    if (cfg_we_i && cfg_addr_i == CFG_PREBUF) begin
      lvl_d = LVL_W'(cfg_wdata_i[PREBUF_W-1:0]);
    end
    if (cmd_i.flush) begin
      rd_d   = '0;
      fill_d = '0;
      run_d  = 1'b0;
    end else if (cmd_i.push_wr) begin
      if (full) begin
        rd_d = wrap(SUM_W'(rd_q) + SUM_W'(1));
      end
      fill_d = fill_new;
      if (CMP_W'(fill_new) >= lvl_ext) begin
        run_d = 1'b1;
      end
    end else begin
      rd_d   = wrap(SUM_W'(rd_q) + SUM_W'(drop_sat));
      fill_d = FILL_W'(fill_q - drop_sat);
      if (cmd_i.emit && cmd_i.last) begin
        if (!cmd_i.silent) begin
          ucnt_d = '0;
        end else if (ucnt_inc >= UNDER_W'(UNDERRUN_LIMIT)) begin
          ucnt_d = '0;
          if (lvl_q < LVL_W'(LVL_CAP)) begin
            if (lvl_sum > (LVL_W + 1)'(LVL_CAP)) begin
              lvl_d = LVL_W'(LVL_CAP);
            end else begin
              lvl_d = LVL_W'(lvl_sum);
            end
          end
        end else begin
          ucnt_d = ucnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      fill_q <= '0;
      lvl_q  <= LVL_W'(PREBUF_RST);
      ucnt_q <= '0;
      run_q  <= 1'b0;
    end else begin
      rd_q   <= rd_d;
      fill_q <= fill_d;
      lvl_q  <= lvl_d;
      ucnt_q <= ucnt_d;
      run_q  <= run_d;
    end
  end

  // sample store
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_acc) begin
      push_q <= sample_in_i;
    end
    if (cmd_i.push_wr) begin
      store_q[waddr] <= push_q;
    end
    rdata_q <= store_q[raddr];
  end

  // output pipeline: read, scale, output register
  assign v_s = rdata_q;

  always_comb begin
    if (v_s > SAMPLE_W'(CLAMP_MAG)) begin
      clamp_s = SAMPLE_W'(CLAMP_MAG);
    end else if (v_s < SAMPLE_W'(-CLAMP_MAG)) begin
      clamp_s = SAMPLE_W'(-CLAMP_MAG);
    end else begin
      clamp_s = v_s;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= PROD_W'(clamp_s) * PROD_W'(INT16_SCALE);
    samp1_q  <= v_s;
    sample_q <= sample_d;
  end

  // truncate toward zero
  assign adj  = prod_q[PROD_W-1] ? PROD_W'(prod_q + PROD_W'(ROUND_BIAS)) : prod_q;
  assign conv = adj >>> FRAC_W;

  always_comb begin
    if (meta1_q.silent) begin
      sample_d = '0;
    end else if (int16_q) begin
      sample_d = conv[SAMPLE_W-1:0];
    end else begin
      sample_d = samp1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta0_q <= '0;
      meta1_q <= '0;
      meta2_q <= '0;
    end else begin
      meta0_q.valid  <= cmd_i.emit;
      meta0_q.last   <= cmd_i.last;
      meta0_q.silent <= cmd_i.silent;
      meta1_q        <= meta0_q;
      meta2_q        <= meta1_q;
    end
  end

  assign result_valid_o  = meta2_q.valid;
  assign is_silence_o    = meta2_q.silent;
  assign last_of_block_o = meta2_q.last;
  assign sample_out_o    = sample_q;

endmodule

>>> rtl/audio_playout_jitter_buffer_top.sv
// audio_playout_jitter_buffer_top: top level of the playout jitter buffer
// depends on apjb_pkg, apjb_ctrl and apjb_datapath
//
// a request is taken when start_i is high and busy_o is low; opcode_i selects
// push (sample_in_i, packet_start_i), tick (sink_suspended_i, sink_bytes_free_i)
// or flush. configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i
// while no request is in progress and all results are out.
// push: busy after acceptance while the sample is written to the store.
// flush, ignored ticks and ticks with little sink space: done at acceptance,
// a new request can follow in the next cycle.
// emitting tick: one store read per cycle, so busy until the block is read; the
// first result passes the read, scale and output registers; the results follow
// on consecutive cycles, each marked by result_valid_o for one cycle.
// the receiver cannot stall; results are never held back.
// reset clears pointers, fill, underrun count and playout state and loads the
// configuration defaults; the sample store has no reset.

module audio_playout_jitter_buffer_top import apjb_pkg::*; #(
  parameter int FIFO_DEPTH = 4096,
  parameter int MAX_BLOCK  = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 opcode_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       packet_start_i,
  input  logic                       sink_suspended_i,
  input  logic [FREE_W-1:0]          sink_bytes_free_i,
  output logic                       result_valid_o,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       is_silence_o,
  output logic                       last_of_block_o
);

  apjb_cmd_t  cmd;
  apjb_stat_t stat;

  apjb_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .opcode_i         (opcode_i),
    .sink_suspended_i (sink_suspended_i),
    .stat_i           (stat),
    .busy_o           (busy_o),
    .cmd_o            (cmd)
  );

  apjb_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .MAX_BLOCK  (MAX_BLOCK)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .sample_in_i       (sample_in_i),
    .packet_start_i    (packet_start_i),
    .sink_bytes_free_i (sink_bytes_free_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .result_valid_o    (result_valid_o),
    .sample_out_o      (sample_out_o),
    .is_silence_o      (is_silence_o),
    .last_of_block_o   (last_of_block_o)
  );

endmodule

>>> rtl/apjb_checker.sv
// apjb_checker: port-level assertions of the jitter buffer and its bind
// depends on apjb_pkg and audio_playout_jitter_buffer_top

module apjb_checker import apjb_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic [1:0]                 opcode_i,
  input logic                       result_valid_o,
  input logic signed [SAMPLE_W-1:0] sample_out_o,
  input logic                       is_silence_o,
  input logic                       last_of_block_o
);

  // silence blocks carry zero samples
  a_silence_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && is_silence_o) |-> (sample_out_o == '0))
    else $error("silence result with nonzero sample");

  // a push request keeps the block busy for its store write
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && opcode_i == OP_PUSH) |=> busy_o)
    else $error("push request not followed by busy");

  // block samples come without gaps
  a_block_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_block_o) |=> result_valid_o)
    else $error("gap inside an output block");

  // a block is either all audio or all silence
  a_block_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_block_o) |=> (is_silence_o == $past(is_silence_o)))
    else $error("silence flag changed inside a block");

endmodule

bind audio_playout_jitter_buffer_top apjb_checker u_apjb_checker (.*);

>>> bench/tb_top.sv
// tb_top: self-checking bench for the audio playout jitter buffer top level
// depends on apjb_pkg and audio_playout_jitter_buffer_top; a directed table is followed by
// random phases and prebuffer growth, with every block sample predicted and compared
`timescale 1ns / 100ps

module tb_top;
  import apjb_pkg::*;

  localparam int DEPTH = 4096;
  localparam int MAXB  = 64;
  localparam int LAT   = 8;
  localparam logic [FREE_W-1:0] ROOM = 16'hFFFF;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       pkt;
    logic                       susp;
    logic [FREE_W-1:0]          space;
  } jb_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       silence;
    logic                       last;
  } jb_sample_t;

  typedef struct packed {
    logic                       wr;
    logic [CFG_IDX_W-1:0]       addr;
    logic [CFG_DATA_W-1:0]      data;
    jb_req_t                    req;
    logic                       typed;
    logic [6:0]                 n_exp;
    logic signed [SAMPLE_W-1:0] exp_sample;
    logic                       exp_sil;
  } jb_row_t;

  localparam jb_req_t NO_REQ    = '{OP_NOP, 24'sd0, 1'b0, 1'b0, 16'd0};
  localparam jb_req_t FULL_TICK = '{OP_TICK, 24'sd0, 1'b0, 1'b0, ROOM};
  localparam jb_req_t FLUSH_REQ = '{OP_FLUSH, 24'sd0, 1'b0, 1'b0, 16'd0};

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i = '0;
  logic                       start_i = 1'b0;
  logic                       busy_o;
  logic [1:0]                 opcode_i = OP_NOP;
  logic signed [SAMPLE_W-1:0] sample_in_i = '0;
  logic                       packet_start_i = 1'b0;
  logic                       sink_suspended_i = 1'b0;
  logic [FREE_W-1:0]          sink_bytes_free_i = '0;
  logic                       result_valid_o;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       is_silence_o;
  logic                       last_of_block_o;

  // predicted state of the buffer and its registers
  logic signed [SAMPLE_W-1:0] fifo_mem [DEPTH];
  int unsigned rd_ptr = 0, fill = 0, pre_level = 256, under_cnt = 0;
  bit          running = 1'b0;
  int unsigned blk_reg = 32, chan_reg = 1;
  bit          pcm16 = 1'b1;

  jb_sample_t block_out [$];
  jb_sample_t expected_samples [$];
  int unsigned errors = 0, n_requests = 0, n_results = 0, n_silent = 0;
  bit          quiet = 1'b0;

  jb_row_t script [] = '{
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, ROOM},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'sh7FFFFF, 1'b1, 1'b0, ROOM},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b1, CFG_BLOCK, 11'd1, NO_REQ, 1'b0, 7'd0, 24'sd0, 1'b0},
    '{1'b1, CFG_PREBUF, 11'd0, NO_REQ, 1'b0, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'sh800000, 1'b0, 1'b0, ROOM},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, ROOM},
      1'b1, 7'd1, 24'sd32767, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, ROOM},
      1'b1, 7'd1, -24'sd32767, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, ROOM},
      1'b1, 7'd1, 24'sd0, 1'b1},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'sh400000, 1'b0, 1'b0, ROOM},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'shFFFFFF, 1'b0, 1'b0, ROOM},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'sh3FFFFF, 1'b0, 1'b0, ROOM},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'shC00001, 1'b0, 1'b0, ROOM},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, ROOM},
      1'b1, 7'd1, 24'sd32767, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, ROOM},
      1'b1, 7'd1, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b1, ROOM},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, 16'd0},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, ROOM},
      1'b1, 7'd1, -24'sd32766, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_NOP, 24'sh5A5A5A, 1'b1, 1'b1, ROOM},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b1, CFG_INT16, 11'd0, NO_REQ, 1'b0, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'sh123456, 1'b0, 1'b0, ROOM},
      1'b0, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'shABCDEF, 1'b1, 1'b0, ROOM},
      1'b0, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, ROOM},
      1'b1, 7'd1, 24'shABCDEF, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'sh000001, 1'b0, 1'b0, ROOM},
      1'b0, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, FLUSH_REQ, 1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, FULL_TICK, 1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b1, CFG_CHAN, 11'd15, NO_REQ, 1'b0, 7'd0, 24'sd0, 1'b0},
    '{1'b1, CFG_BLOCK, 11'd127, NO_REQ, 1'b0, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_PUSH, 24'sh7FFFFF, 1'b0, 1'b0, ROOM},
      1'b0, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, 16'd1919},
      1'b1, 7'd0, 24'sd0, 1'b0},
    '{1'b0, CFG_BLOCK, 11'd0, '{OP_TICK, 24'sd0, 1'b0, 1'b0, 16'd1920},
      1'b1, 7'd64, 24'sd0, 1'b1}
  };

  audio_playout_jitter_buffer_top #(
    .FIFO_DEPTH(DEPTH),
    .MAX_BLOCK (MAXB)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .sample_in_i      (sample_in_i),
    .packet_start_i   (packet_start_i),
    .sink_suspended_i (sink_suspended_i),
    .sink_bytes_free_i(sink_bytes_free_i),
    .result_valid_o   (result_valid_o),
    .sample_out_o     (sample_out_o),
    .is_silence_o     (is_silence_o),
    .last_of_block_o  (last_of_block_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned eff_block();
    if (blk_reg == 0) return 1;
    if (blk_reg > MAXB) return MAXB;
    return blk_reg;
  endfunction

  function automatic void drop_oldest(input int unsigned n);
    if (n > fill) n = fill;
    rd_ptr = (rd_ptr + n) % DEPTH;
    fill = fill - n;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] scale_to_pcm16(
    input logic signed [SAMPLE_W-1:0] v
  );
    longint c, p;
    c = v;
    if (c > CLAMP_MAG) c = CLAMP_MAG;
    if (c < -CLAMP_MAG) c = -CLAMP_MAG;
    p = c * INT16_SCALE;
    p = (p >= 0) ? p / CLAMP_MAG : -((-p) / CLAMP_MAG);
    return SAMPLE_W'(p);
  endfunction

  // advances the predicted buffer by one request and leaves its samples in block_out
  task automatic predict_playout(input jb_req_t r);
    int unsigned blk, bytes, i;
    bit silent;
    logic signed [SAMPLE_W-1:0] v;
    block_out.delete();
    blk = eff_block();
    case (r.op)
      OP_PUSH: begin
        if (r.pkt && fill > 4 * pre_level) drop_oldest(2 * blk);
        if (fill >= DEPTH) drop_oldest(1);
        fifo_mem[(rd_ptr + fill) % DEPTH] = r.sample;
        fill++;
        if (!running && fill >= pre_level) running = 1'b1;
      end
      OP_FLUSH: begin
        fill = 0;
        rd_ptr = 0;
        running = 1'b0;
      end
      OP_TICK: begin
        if (running && !r.susp) begin
          bytes = blk * chan_reg * (pcm16 ? 2 : 4);
          if (r.space < bytes / 2) begin
            if (fill > 3 * pre_level) drop_oldest(blk);
          end else begin
            silent = fill < blk;
            for (i = 0; i < blk; i++) begin
              v = '0;
              if (!silent) begin
                v = fifo_mem[(rd_ptr + i) % DEPTH];
                if (pcm16) v = scale_to_pcm16(v);
              end
              block_out.push_back('{sample: v, silence: silent, last: i == blk - 1});
            end
            if (!silent) begin
              drop_oldest(blk);
              under_cnt = 0;
            end else begin
              under_cnt++;
              if (under_cnt >= UNDERRUN_LIMIT) begin
                under_cnt = 0;
                if (pre_level < DEPTH / 4) begin
                  pre_level += blk;
                  if (pre_level > DEPTH / 4) pre_level = DEPTH / 4;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] corner [8] = '{24'sh7FFFFF, 24'sh800000, 24'sh400000,
      24'shC00000, 24'sh3FFFFF, 24'shC00001, 24'sh000000, 24'shFFFFFF};
    if ($urandom_range(99) < 20) return corner[$urandom_range(7)];
    return SAMPLE_W'($urandom);
  endfunction

  function automatic jb_req_t rand_push();
    jb_req_t r;
    r = '{OP_PUSH, rand_sample(), $urandom_range(3) == 0, 1'b0, ROOM};
    return r;
  endfunction

  function automatic jb_req_t rand_req(input int unsigned tick_pct);
    jb_req_t r;
    int unsigned pick, half;
    half = eff_block() * chan_reg * (pcm16 ? 2 : 4) / 2;
    pick = $urandom_range(99);
    if (pick < 95 - tick_pct) r.op = OP_PUSH;
    else if (pick < 95) r.op = OP_TICK;
    else if (pick < 97) r.op = OP_FLUSH;
    else r.op = OP_NOP;
    r.sample = rand_sample();
    r.pkt = $urandom_range(99) < 25;
    r.susp = $urandom_range(99) < 10;
    pick = $urandom_range(99);
    if (pick < 8) r.space = FREE_W'(half);
    else if (pick < 16) r.space = (half == 0) ? '0 : FREE_W'(half - 1);
    else r.space = FREE_W'($urandom);
    return r;
  endfunction

  task automatic send_request(input jb_req_t r, input bit from_model = 1'b1);
    int unsigned i;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    while (!quiet && $urandom_range(99) < 9) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i = 1'b1;
    opcode_i = r.op;
    sample_in_i = r.sample;
    packet_start_i = r.pkt;
    sink_suspended_i = r.susp;
    sink_bytes_free_i = r.space;
    do @(posedge clk_i); while (busy_o);
    n_requests++;
    predict_playout(r);
    if (from_model)
      for (i = 0; i < block_out.size(); i++) expected_samples.push_back(block_out[i]);
  endtask

  // holds requests off until every predicted sample is out
  task automatic settle(input int unsigned extra);
    @(negedge clk_i);
    start_i = 1'b0;
    cfg_we_i = 1'b0;
    while (expected_samples.size() != 0 || busy_o) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    start_i = 1'b0;
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    case (idx)
      CFG_BLOCK:  blk_reg = val[BLK_W-1:0];
      CFG_PREBUF: pre_level = val;
      CFG_CHAN:   chan_reg = val[CHAN_W-1:0];
      CFG_INT16:  pcm16 = val[0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] blk, input logic [CFG_DATA_W-1:0] pre,
                           input logic [CFG_DATA_W-1:0] chan, input logic [CFG_DATA_W-1:0] i16,
                           input int unsigned n, input int unsigned tick_pct);
    int unsigned k;
    settle(LAT);
    cfg_write(CFG_BLOCK, blk);
    cfg_write(CFG_PREBUF, pre);
    cfg_write(CFG_CHAN, chan);
    cfg_write(CFG_INT16, i16);
    for (k = 0; k < n; k++) begin
      send_request(rand_req(tick_pct));
      if ($urandom_range(99) < 3) settle(0);
    end
  endtask

  always @(posedge clk_i) begin
    jb_sample_t want;
    if (result_valid_o) begin
      n_results++;
      if (is_silence_o) n_silent++;
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors < 50)
          $display("%0t: unexpected sample %0d silence %0b last %0b", $time, sample_out_o,
                   is_silence_o, last_of_block_o);
      end else begin
        want = expected_samples.pop_front();
        if (sample_out_o !== want.sample) begin
          errors++;
          if (errors < 50)
            $display("%0t: sample_out expected %0d actual %0d", $time, want.sample,
                     sample_out_o);
        end
        if (is_silence_o !== want.silence) begin
          errors++;
          if (errors < 50)
            $display("%0t: is_silence expected %0b actual %0b", $time, want.silence,
                     is_silence_o);
        end
        if (last_of_block_o !== want.last) begin
          errors++;
          if (errors < 50)
            $display("%0t: last_of_block expected %0b actual %0b", $time, want.last,
                     last_of_block_o);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned k, j;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (script[k]) begin
      if (script[k].wr) begin
        settle(LAT);
        cfg_write(script[k].addr, script[k].data);
      end else begin
        send_request(script[k].req, !script[k].typed);
        if (script[k].typed)
          for (j = 0; j < script[k].n_exp; j++)
            expected_samples.push_back('{sample: script[k].exp_sample,
                                         silence: script[k].exp_sil,
                                         last: j == script[k].n_exp - 1});
      end
    end

    run_phase(11'd0, 11'd0, 11'd1, 11'd1, 45, 40);
    // upper data bits set on purpose, only the register width is kept
    run_phase(11'h740, 11'd2, 11'h7F8, 11'h7FE, 45, 4);
    run_phase(11'd127, 11'd16, 11'd0, 11'd1, 40, 6);
    quiet = 1'b1;
    run_phase(11'd3, 11'd1, 11'd15, 11'd0, 45, 25);
    quiet = 1'b0;
    run_phase(CFG_DATA_W'($urandom_range(1, 64)), CFG_DATA_W'($urandom_range(0, 12)),
              CFG_DATA_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom_range(0, 1)), 40, 15);
    run_phase(11'd9, 11'd3, 11'd2, 11'd1, 40, 20);

    // prebuffer growth up to its cap
    settle(LAT);
    cfg_write(CFG_BLOCK, 11'd64);
    cfg_write(CFG_PREBUF, 11'd8);
    cfg_write(CFG_CHAN, 11'd1);
    cfg_write(CFG_INT16, 11'd1);
    for (k = 0; k < 8; k++) send_request(rand_push());
    settle(LAT);
    cfg_write(CFG_PREBUF, 11'd1000);
    for (k = 0; k < 26; k++) send_request(FULL_TICK);

    // level above the cap is kept through underruns
    settle(LAT);
    cfg_write(CFG_PREBUF, 11'd2047);
    for (k = 0; k < 26; k++) send_request(FULL_TICK);
    for (k = 0; k < 12; k++) send_request(rand_req(30));

    settle(LAT);
    $display("%0d requests sent, %0d block samples checked, %0d of them silence",
             n_requests, n_results, n_silent);
    $display("block sizes 1 to 64, both output modes, overflow drops and prebuffer growth");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
